### rtl/oul_pkg.sv
`timescale 1ns / 1ps

package oul_pkg;

  // Fixed field widths of the item ports
  localparam int OP_W     = 3;
  localparam int KEY_W    = 32;
  localparam int OFF_W    = 5;
  localparam int STATUS_W = 3;
  localparam int FIELD_W  = 5;

  // Default sizing
  localparam int CAPACITY_DEF  = 16;
  localparam int KEY_WIDTH_DEF = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INS_OFF = 3'd0,
    OP_INS_TOP = 3'd1,
    OP_INS_BOT = 3'd2,
    OP_RM_KEY  = 3'd3,
    OP_RM_OFF  = 3'd4,
    OP_TO_TOP  = 3'd5,
    OP_FIND    = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_DUP       = 3'd1,
    ST_BAD_OFF   = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // Per-cell update command
  typedef enum logic [1:0] {
    CC_HOLD  = 2'd0,
    CC_LOAD  = 2'd1,
    CC_LEFT  = 2'd2,
    CC_RIGHT = 2'd3
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CMP  = 2'd1,
    S_UPD  = 2'd2
  } fsm_t;

endpackage

### rtl/oul_cell.sv
`timescale 1ns / 1ps

module oul_cell #(
  parameter int KW = oul_pkg::KEY_WIDTH_DEF
) (
  input  logic              clk,
  input  oul_pkg::cell_cmd_t cmd,
  input  logic [KW-1:0]     key,
  input  logic [KW-1:0]     left_key,
  input  logic [KW-1:0]     right_key,
  input  logic              occupied,
  output logic [KW-1:0]     key_q,
  output logic              match
);
  import oul_pkg::*;

  logic [KW-1:0] key_r;
  logic [KW-1:0] key_nxt;

  // Shift / load select
  always_comb begin
    case (cmd)
      CC_LOAD:  key_nxt = key;
      CC_LEFT:  key_nxt = left_key;
      CC_RIGHT: key_nxt = right_key;
      default:  key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  // Only live entries may match
  assign match = occupied && (key_r == key);
  assign key_q = key_r;

endmodule

### rtl/ordered_unique_list_engine.sv
`timescale 1ns / 1ps
// An accepted item is handled in a compare state (S_CMP) and then a shift state (S_UPD).
// The compare state matches the key against every cell of the row; the shift state shifts
// the row by one place and counts. A new item is taken while idle or as a result commits.
// A stalled result holds the shift cycle until the output register is free.
// Reset (rst_n low, synchronous) empties the list and clears control; cell keys are not reset.
module ordered_unique_list_engine #(
  parameter int CAPACITY  = oul_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = oul_pkg::KEY_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [oul_pkg::OP_W-1:0]      in_op,
  input  logic [oul_pkg::KEY_W-1:0]     in_key,
  input  logic [oul_pkg::OFF_W-1:0]     in_offset,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [oul_pkg::STATUS_W-1:0]  out_status,
  output logic [oul_pkg::FIELD_W-1:0]   out_position,
  output logic [oul_pkg::FIELD_W-1:0]   out_count
);
  import oul_pkg::*;

  localparam int KW   = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > OFF_W) ? CW : OFF_W;

  fsm_t state_r, state_nxt;
  logic accept, commit;

  // Item registers
  op_t              op_r;
  logic [KW-1:0]    key_r;
  logic [OFF_W-1:0] off_r;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] where_r, where_c;
  logic          found_r, found_c;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [FIELD_W-1:0]  out_position_r;
  logic [FIELD_W-1:0]  out_count_r;

  // Cell row
  logic [KW-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0] match;
  cell_cmd_t cmd [CAPACITY];

  // Update decode
  logic          do_ins, do_rm, do_mtf;
  logic [CW-1:0] ins_pos;
  logic [IW-1:0] ins_idx, rm_idx;
  status_t       status_c;
  logic [CW-1:0] pos_c;
  logic [CW-1:0] cnt_dec;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_UPD;
      S_UPD: begin
        if (commit) state_nxt = accept ? S_CMP : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    commit   = (state_r == S_UPD) && (!out_valid_r || !out_stall);
    in_stall = !((state_r == S_IDLE) || commit);
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(in_op);
      key_r <= in_key[KW-1:0];
      off_r <= in_offset;
    end
  end

  // Cells
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      localparam int LI = (gi == 0) ? 0 : gi - 1;
      localparam int RI = (gi == CAPACITY - 1) ? gi : gi + 1;

      always_comb begin
        cmd[gi] = CC_HOLD;
        if (commit) begin
          if (do_ins) begin
            if (IW'(gi) == ins_idx) cmd[gi] = CC_LOAD;
            else if (IW'(gi) > ins_idx) cmd[gi] = CC_LEFT;
          end else if (do_mtf) begin
            if (gi == 0) cmd[gi] = CC_LOAD;
            else if (IW'(gi) <= where_r) cmd[gi] = CC_LEFT;
          end else if (do_rm) begin
            if (gi != CAPACITY - 1 && IW'(gi) >= rm_idx) cmd[gi] = CC_RIGHT;
          end
        end
      end

      oul_cell #(.KW(KW)) u_cell (
        .clk       (clk),
        .cmd       (cmd[gi]),
        .key       (key_r),
        .left_key  (cell_key[LI]),
        .right_key (cell_key[RI]),
        .occupied  (CW'(gi) < cnt_r),
        .key_q     (cell_key[gi]),
        .match     (match[gi])
      );
    end
  endgenerate

  // Locate: keys are unique, so at most one live cell matches
  always_comb begin
    where_c = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) where_c = where_c | IW'(i);
    end
    found_c = |match;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CMP) begin
      where_r <= where_c;
      found_r <= found_c;
    end
  end

  // Operation decode, status and resulting position
  always_comb begin
    do_ins   = 1'b0;
    do_rm    = 1'b0;
    do_mtf   = 1'b0;
    ins_pos  = '0;
    rm_idx   = where_r;
    status_c = ST_DONE;
    cnt_dec  = cnt_r - CW'(1);
    pos_c    = found_r ? CW'(where_r) : cnt_r;
    case (op_r)
      OP_INS_OFF, OP_INS_TOP, OP_INS_BOT: begin
        if (op_r == OP_INS_OFF) ins_pos = CW'(off_r);
        else if (op_r == OP_INS_BOT) ins_pos = cnt_r;
        if (op_r == OP_INS_OFF && CMPW'(off_r) > CMPW'(cnt_r)) status_c = ST_BAD_OFF;
        else if (found_r) status_c = ST_DUP;
        else if (cnt_r >= CW'(CAPACITY)) status_c = ST_FULL;
        else begin
          do_ins = 1'b1;
          pos_c  = ins_pos;
        end
      end
      OP_RM_KEY: begin
        if (found_r) begin
          do_rm = 1'b1;
          pos_c = cnt_dec;
        end else begin
          status_c = ST_NOT_FOUND;
        end
      end
      OP_RM_OFF: begin
        if (CMPW'(off_r) < CMPW'(cnt_r)) begin
          do_rm  = 1'b1;
          rm_idx = IW'(off_r);
          if (!found_r || where_r == IW'(off_r)) pos_c = cnt_dec;
          else if (where_r > IW'(off_r)) pos_c = CW'(where_r) - CW'(1);
          else pos_c = CW'(where_r);
        end else begin
          status_c = ST_BAD_OFF;
        end
      end
      OP_TO_TOP: begin
        if (found_r) begin
          do_mtf = 1'b1;
          pos_c  = '0;
        end else begin
          status_c = ST_NOT_FOUND;
        end
      end
      OP_FIND: begin
        if (!found_r) status_c = ST_NOT_FOUND;
      end
      default: status_c = ST_DONE;
    endcase
  end

  assign ins_idx = IW'(ins_pos);

  // Entry count
  always_comb begin
    cnt_nxt = cnt_r;
    if (commit && do_ins) cnt_nxt = cnt_r + CW'(1);
    else if (commit && do_rm) cnt_nxt = cnt_dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r   <= status_c;
      out_position_r <= FIELD_W'(pos_c);
      out_count_r    <= FIELD_W'(cnt_nxt);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_position_r;
  assign out_count    = out_count_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_out_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_UPD))
    else $error("result raised outside shift cycle");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && do_ins) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("insert did not grow the list");

  a_no_change_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && !commit) |=> $stable(cnt_r))
    else $error("count moved while result stalled");

endmodule
